### hdl/fitness_wheel_selector_defines.svh
// Assertion macros for the fitness wheel selector.
// Uses clk and rst_n of the module that includes it; no other dependencies.
`ifndef FITNESS_WHEEL_SELECTOR_DEFINES_SVH
`define FITNESS_WHEEL_SELECTOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define FWS_ASSERT_IMPLY(name, a, b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("fws: implication check failed");

`define FWS_ASSERT_NEXT(name, a, b) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("fws: next-cycle check failed");

`define FWS_ASSERT_ALWAYS(name, a) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
        else $error("fws: invariant check failed");

`else

`define FWS_ASSERT_IMPLY(name, a, b)
`define FWS_ASSERT_NEXT(name, a, b)
`define FWS_ASSERT_ALWAYS(name, a)

`endif

`endif

### hdl/fws_pkg.sv
// Shared constants, state type and controller/datapath interface structs
// for the fitness wheel selector. No dependencies.
package fws_pkg;

    localparam int POP_MAX   = 256;
    localparam int IDX_W     = $clog2(POP_MAX);
    localparam int POP_W     = IDX_W + 1;
    localparam int FIT_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int SUM_W     = FIT_W + IDX_W;
    localparam int PROD_W    = SUM_W + FRAC_W;
    localparam int CFG_W     = POP_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POP  = 1'b1;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_SPIN    = 1'b1;
    localparam logic MODE_RANKED = 1'b1;

    localparam logic [POP_W-1:0] POP_RESET = POP_W'(POP_MAX);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_SUM_TAIL,
        ST_MUL,
        ST_SCAN,
        ST_RANK,
        ST_WAIT_OUT
    } fws_state_t;

    typedef struct packed {
        logic load_we;
        logic spin_start;
        logic sum_issue;
        logic sum_acc;
        logic mul;
        logic scan_issue;
        logic rank_step;
        logic push_out;
    } fws_cmd_t;

    typedef struct packed {
        logic ranked;
        logic idx_last;
        logic scan_hit;
        logic rank_done;
        logic out_free;
    } fws_status_t;

endpackage

### hdl/fws_datapath.sv
// Datapath: fitness store, config registers, sum/scan accumulators,
// wheel multiplier and output register. Depends on fws_pkg.
module fws_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fws_pkg::fws_cmd_t                 cmd,
    output fws_pkg::fws_status_t              status,
    input  logic                              cfg_write,
    input  logic [fws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fws_pkg::CFG_W-1:0]         cfg_data,
    input  logic [fws_pkg::IDX_W-1:0]         entry_index,
    input  logic [fws_pkg::FIT_W-1:0]         fitness_value,
    input  logic [fws_pkg::FRAC_W-1:0]        random_fraction,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [fws_pkg::IDX_W-1:0]         selected_index
);
    import fws_pkg::*;

    logic [FIT_W-1:0]  mem [POP_MAX];
    logic [FIT_W-1:0]  rd_data_reg;

    logic              mode_reg;
    logic [POP_W-1:0]  pop_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  didx_reg;
    logic              dv_reg, dv_next;
    logic              out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  partial_reg, partial_next;
    logic [SUM_W-1:0]  wheel_reg, wheel_next;
    logic [SUM_W-1:0]  total_reg;
    logic [FRAC_W-1:0] r_reg;
    logic [IDX_W-1:0]  last_reg;
    logic [IDX_W-1:0]  sel_reg, sel_next;
    logic [IDX_W-1:0]  out_data_reg;

    logic [IDX_W-1:0]   last_cfg;
    logic [POP_W-1:0]   n_eff;
    logic [2*POP_W-1:0] tri_prod;
    logic [SUM_W-1:0]   mul_operand;
    logic [PROD_W-1:0]  wheel_prod;
    logic [SUM_W-1:0]   partial_add;
    logic               idx_last;
    logic               scan_hit;
    logic               rank_done;

    // active entry count: zero acts as one, large values saturate
    always_comb
    begin
        if (pop_reg == '0)
            last_cfg = '0;
        else if (pop_reg > POP_W'(POP_MAX))
            last_cfg = IDX_W'(POP_MAX - 1);
        else
            last_cfg = IDX_W'(pop_reg - POP_W'(1));
    end

    assign n_eff       = POP_W'(last_cfg) + POP_W'(1);
    assign tri_prod    = (2*POP_W)'(n_eff) * ((2*POP_W)'(n_eff) + (2*POP_W)'(1));
    assign mul_operand = (mode_reg == MODE_RANKED) ? total_reg : sum_reg;
    assign wheel_prod  = PROD_W'(r_reg) * PROD_W'(mul_operand);
    assign partial_add = partial_reg + SUM_W'(rd_data_reg);

    assign idx_last  = (idx_reg == last_reg);
    assign scan_hit  = dv_reg && ((partial_add >= wheel_reg) || (didx_reg == last_reg));
    assign rank_done = idx_last || (partial_reg >= wheel_reg);

    assign status.ranked    = (mode_reg == MODE_RANKED);
    assign status.idx_last  = idx_last;
    assign status.scan_hit  = scan_hit;
    assign status.rank_done = rank_done;
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        partial_next   = partial_reg;
        wheel_next     = wheel_reg;
        sel_next       = sel_reg;
        dv_next        = cmd.sum_issue || cmd.scan_issue;
        out_valid_next = out_valid_reg;

        if (cmd.spin_start || cmd.mul)
            idx_next = '0;
        else if (cmd.sum_issue || cmd.scan_issue)
            idx_next = idx_last ? idx_reg : idx_reg + IDX_W'(1);
        else if (cmd.rank_step && !rank_done)
            idx_next = idx_reg + IDX_W'(1);

        if (cmd.spin_start)
            sum_next = '0;
        else if (cmd.sum_acc && dv_reg)
            sum_next = sum_reg + SUM_W'(rd_data_reg);

        if (cmd.mul)
            partial_next = '0;
        else if (cmd.scan_issue && dv_reg)
            partial_next = partial_add;
        else if (cmd.rank_step && !rank_done)
            partial_next = partial_reg + SUM_W'(idx_reg) + SUM_W'(1);

        if (cmd.mul)
            wheel_next = SUM_W'(wheel_prod >> FRAC_W);

        if (cmd.scan_issue && scan_hit)
            sel_next = didx_reg;
        else if (cmd.rank_step && rank_done)
            sel_next = idx_reg;

        if (cmd.push_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            pop_reg       <= POP_RESET;
            idx_reg       <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_data[0];
                    CFG_POP:  pop_reg  <= cfg_data[POP_W-1:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg    <= idx_reg;
        sum_reg     <= sum_next;
        partial_reg <= partial_next;
        wheel_reg   <= wheel_next;
        sel_reg     <= sel_next;
        if (cmd.spin_start)
        begin
            r_reg     <= random_fraction;
            last_reg  <= last_cfg;
            total_reg <= SUM_W'(tri_prod >> 1);
        end
        if (cmd.push_out)
            out_data_reg <= sel_reg;
    end

    // fitness store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
            mem[entry_index] <= fitness_value;
        rd_data_reg <= mem[idx_reg];
    end

    assign out_valid      = out_valid_reg;
    assign selected_index = out_data_reg;

endmodule

### hdl/fws_controller.sv
// Sequencer for the fitness wheel selector: accepts requests and steps
// the datapath through sum, multiply and scan/rank phases. Depends on fws_pkg.
module fws_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 action,
    output logic                 in_stall,
    input  fws_pkg::fws_status_t status,
    output fws_pkg::fws_cmd_t    cmd
);
    import fws_pkg::*;

    fws_state_t state_reg, state_next;
    logic       idle;

    assign idle = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && action == ACT_SPIN)
                    state_next = status.ranked ? ST_MUL : ST_SUM;
            end
            ST_SUM:
            begin
                if (status.idx_last)
                    state_next = ST_SUM_TAIL;
            end
            ST_SUM_TAIL:
                state_next = ST_MUL;
            ST_MUL:
                state_next = status.ranked ? ST_RANK : ST_SCAN;
            ST_SCAN:
            begin
                if (status.scan_hit)
                    state_next = ST_WAIT_OUT;
            end
            ST_RANK:
            begin
                if (status.rank_done)
                    state_next = ST_WAIT_OUT;
            end
            ST_WAIT_OUT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall       = !idle;
        cmd            = '0;
        cmd.load_we    = idle && in_valid && (action == ACT_LOAD);
        cmd.spin_start = idle && in_valid && (action == ACT_SPIN);
        case (state_reg)
            ST_IDLE:     ;
            ST_SUM:
            begin
                cmd.sum_issue = 1'b1;
                cmd.sum_acc   = 1'b1;
            end
            ST_SUM_TAIL: cmd.sum_acc    = 1'b1;
            ST_MUL:      cmd.mul        = 1'b1;
            ST_SCAN:     cmd.scan_issue = 1'b1;
            ST_RANK:     cmd.rank_step  = 1'b1;
            ST_WAIT_OUT: cmd.push_out   = status.out_free;
            default:     ;
        endcase
    end

endmodule

### hdl/fitness_wheel_selector.sv
// Top level of the fitness wheel selector: controller plus datapath.
// Depends on fws_pkg, fws_controller, fws_datapath and the defines header.
//
//   channel  handshake               payload
//   in       in_valid / in_stall     action, entry_index, fitness_value, random_fraction
//   out      out_valid / out_stall   selected_index
//   cfg      cfg_write               cfg_index, cfg_data
//
// A load writes the store on acceptance.
// A roulette spin reads the store once per cycle over the N active entries
// to sum, then multiplies, then reads once per cycle to scan.
// A ranked spin makes one walk step per cycle.
// Reset returns control and config to defaults (roulette mode, population POP_MAX);
// the store stays undefined until loaded. A finished result waits in the output
// register; a new request is taken meanwhile, and only a second result stalls behind it.
`include "fitness_wheel_selector_defines.svh"

module fitness_wheel_selector (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [fws_pkg::IDX_W-1:0]      entry_index,
    input  logic [fws_pkg::FIT_W-1:0]      fitness_value,
    input  logic [fws_pkg::FRAC_W-1:0]     random_fraction,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [fws_pkg::IDX_W-1:0]      selected_index,
    input  logic                           cfg_write,
    input  logic [fws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fws_pkg::CFG_W-1:0]      cfg_data
);
    import fws_pkg::*;

    fws_cmd_t    cmd;
    fws_status_t status;

    fws_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fws_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .entry_index     (entry_index),
        .fitness_value   (fitness_value),
        .random_fraction (random_fraction),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .selected_index  (selected_index)
    );

    `FWS_ASSERT_IMPLY(a_push_into_free, cmd.push_out, !(out_valid && out_stall))
    `FWS_ASSERT_NEXT(a_spin_busy, in_valid && !in_stall && action == ACT_SPIN, in_stall)
    `FWS_ASSERT_ALWAYS(a_one_phase, $onehot0({cmd.sum_issue, cmd.mul, cmd.scan_issue, cmd.rank_step, cmd.push_out}))

endmodule
